/* src/m4i_pkg.sv */
// m4i_pkg: shared types, constants and helpers for the 4x4 matrix inverse.
// Used by m4i_lane, m4i_merge and matrix4_inverse; depends on nothing.
package m4i_pkg;

   localparam int DEF_ELEM_WIDTH = 32;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int NUM_LANES      = 4;

   typedef enum logic [2:0] {
      T_IDLE,
      T_WRITE,
      T_COF,
      T_MERGE,
      T_DIV,
      T_EMIT
   } top_state_type;

   typedef enum logic [3:0] {
      LN_IDLE,
      LN_ADDR_A,
      LN_ADDR_B,
      LN_LATCH,
      LN_MUL,
      LN_ACCUM,
      LN_STORE,
      LN_HOLD,
      LN_DIV_SETUP,
      LN_DIV_ADD,
      LN_DIV_CHECK,
      LN_DIV_ITER,
      LN_DIV_END,
      LN_FIN
   } lane_state_type;

   // multiply-accumulate step kinds of a lane
   typedef enum logic [1:0] {
      OP_SA,   // first 2x2 product
      OP_SB,   // second 2x2 product, subtracted
      OP_ACC,  // element times sub-factor into the cofactor sum
      OP_DET   // column-0 element times cofactor, for the determinant
   } op_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic       start_cof;
      logic       start_div;
   } lane_ctl_type;

   typedef struct packed {
      logic cof_ready;
      logic div_ready;
   } lane_sts_type;

   function automatic int prod_w(input int w);
      return 4 * w + 3;
   endfunction

   function automatic int det_w(input int w);
      return 4 * w + 5;
   endfunction

   // k-th index of 0..3 with one index left out
   function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] k);
      return (k >= skip) ? k + 2'd1 : k;
   endfunction

   function automatic logic [1:0] next3(input logic [1:0] k);
      return (k == 2'd2) ? 2'd0 : k + 2'd1;
   endfunction

endpackage

/* src/matrix4_inverse.sv */
// matrix4_inverse: top level of the 4x4 fixed-point matrix inverse.
// Depends on m4i_pkg, m4i_lane (four lanes) and m4i_merge.
//
//   channel   ports                               handshake
//   request   req_column_index, req_elem_0..3     start & !busy
//   result    rsp_out_column, rsp_inv_0..3,       rsp_valid, one per result
//             rsp_singular, rsp_saturated, rsp_last
//
// A request for columns 0..2 holds busy while it is written into the four lane
// copies of the matrix, one element per cycle.
// A request for column 3 runs the inversion: each lane works out one adjugate
// column with a one-bit-per-cycle multiplier (9 products per cofactor) and then
// a restoring divider, one quotient bit per cycle; then four results on
// consecutive cycles. Results cannot be stalled; busy only holds off requests.
// Synchronous reset; the matrix copies keep no reset value.
module matrix4_inverse #(
   parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH,
   parameter int FRAC_BITS  = m4i_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_column_index,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_0,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_1,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_2,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_3,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_out_column,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_0,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_3,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last
);

   localparam int W      = ELEM_WIDTH;
   localparam int PROD_W = m4i_pkg::prod_w(W);
   localparam int DET_W  = m4i_pkg::det_w(W);
   localparam int NL     = m4i_pkg::NUM_LANES;

   m4i_pkg::top_state_type state_ff, state_in;
   logic [1:0]             col_ff, wcnt_ff, ecnt_ff;
   logic [W-1:0]           elem_ff [4];

   m4i_pkg::lane_ctl_type      lane_ctl;
   m4i_pkg::lane_sts_type      lane_sts [NL];
   logic signed [3:0][PROD_W-1:0] lane_prod;
   logic [3:0][W-1:0]          lane_res [NL];
   logic [NL-1:0]              lane_sat, cof_ready, div_ready;
   logic                       all_cof, all_div, merge_en, det_valid, det_zero;
   logic signed [DET_W-1:0]    det;

   logic                       rsp_valid_ff, singular_ff, saturated_ff, last_ff;
   logic [1:0]                 out_column_ff;
   logic [W-1:0]               inv_ff [4];

   for (genvar g = 0; g < NL; g++) begin : g_lane
      m4i_lane #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .LANE       (g)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .wr_data (elem_ff[wcnt_ff]),
         .det     (det),
         .sts     (lane_sts[g]),
         .prod    (lane_prod[g]),
         .res     (lane_res[g]),
         .sat     (lane_sat[g])
      );
      assign cof_ready[g] = lane_sts[g].cof_ready;
      assign div_ready[g] = lane_sts[g].div_ready;
   end

   m4i_merge #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (merge_en),
      .prod      (lane_prod),
      .det       (det),
      .det_valid (det_valid)
   );

   assign all_cof  = &cof_ready;
   assign all_div  = &div_ready;
   assign det_zero = (det == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         m4i_pkg::T_IDLE: begin
            if (start) state_in = m4i_pkg::T_WRITE;
         end
         m4i_pkg::T_WRITE: begin
            if (wcnt_ff == 2'd3) state_in = (col_ff == 2'd3) ? m4i_pkg::T_COF : m4i_pkg::T_IDLE;
         end
         m4i_pkg::T_COF: begin
            if (all_cof) state_in = m4i_pkg::T_MERGE;
         end
         m4i_pkg::T_MERGE: begin
            if (det_valid) state_in = m4i_pkg::T_DIV;
         end
         m4i_pkg::T_DIV: begin
            if (all_div) state_in = m4i_pkg::T_EMIT;
         end
         m4i_pkg::T_EMIT: begin
            if (ecnt_ff == 2'd3) state_in = m4i_pkg::T_IDLE;
         end
         default: state_in = m4i_pkg::T_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy               = (state_ff != m4i_pkg::T_IDLE);
      lane_ctl.wr_en     = (state_ff == m4i_pkg::T_WRITE);
      lane_ctl.wr_addr   = {col_ff, wcnt_ff};
      lane_ctl.start_cof = (state_ff == m4i_pkg::T_WRITE) && (wcnt_ff == 2'd3)
                           && (col_ff == 2'd3);
      lane_ctl.start_div = (state_ff == m4i_pkg::T_MERGE) && det_valid;
      merge_en           = (state_ff == m4i_pkg::T_COF) && all_cof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= m4i_pkg::T_IDLE;
         wcnt_ff      <= 2'd0;
         ecnt_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == m4i_pkg::T_EMIT);
         if (state_ff == m4i_pkg::T_WRITE) wcnt_ff <= wcnt_ff + 2'd1;
         if (state_ff == m4i_pkg::T_EMIT)  ecnt_ff <= ecnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         col_ff     <= req_column_index;
         elem_ff[0] <= req_elem_0;
         elem_ff[1] <= req_elem_1;
         elem_ff[2] <= req_elem_2;
         elem_ff[3] <= req_elem_3;
      end
      if (state_ff == m4i_pkg::T_EMIT) begin
         out_column_ff <= ecnt_ff;
         singular_ff   <= det_zero;
         saturated_ff  <= !det_zero && lane_sat[ecnt_ff];
         last_ff       <= (ecnt_ff == 2'd3);
         for (int i = 0; i < 4; i++) begin
            inv_ff[i] <= det_zero ? '0 : lane_res[ecnt_ff][i];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = out_column_ff;
   assign rsp_inv_0      = inv_ff[0];
   assign rsp_inv_1      = inv_ff[1];
   assign rsp_inv_2      = inv_ff[2];
   assign rsp_inv_3      = inv_ff[3];
   assign rsp_singular   = singular_ff;
   assign rsp_saturated  = saturated_ff;
   assign rsp_last       = last_ff;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv_0 == '0 && rsp_inv_1 == '0
         && rsp_inv_2 == '0 && rsp_inv_3 == '0 && !rsp_saturated)
      else $error("singular result carries nonzero data");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_column == 2'd3)
      else $error("last flag on wrong column");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_column != 2'd0 |-> $past(rsp_valid))
      else $error("result burst broken");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

endmodule

/* src/m4i_lane.sv */
// m4i_lane: one lane of the inverse; own copy of the matrix, serial multiplier,
// cofactors of one adjugate column, and a restoring divider. Uses m4i_pkg.
module m4i_lane #(
   parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH,
   parameter int FRAC_BITS  = m4i_pkg::DEF_FRAC_BITS,
   parameter int LANE       = 0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  m4i_pkg::lane_ctl_type                          ctl,
   input  logic [ELEM_WIDTH-1:0]                          wr_data,
   input  logic signed [m4i_pkg::det_w(ELEM_WIDTH)-1:0]   det,
   output m4i_pkg::lane_sts_type                          sts,
   output logic signed [m4i_pkg::prod_w(ELEM_WIDTH)-1:0]  prod,
   output logic [3:0][ELEM_WIDTH-1:0]                     res,
   output logic                                           sat
);

   localparam int W      = ELEM_WIDTH;
   localparam int CNT_W  = $clog2(W);
   localparam int S_W    = 2 * W + 1;
   localparam int COF_W  = 3 * W + 3;
   localparam int PROD_W = m4i_pkg::prod_w(W);
   localparam int DET_W  = m4i_pkg::det_w(W);
   localparam int NUM_W  = 4 * W + 2 * FRAC_BITS + 6;
   localparam int DIV_W  = NUM_W + W;
   localparam int SH     = 2 * FRAC_BITS + 1;
   localparam logic [1:0] ROW_ID = 2'(LANE);

   m4i_pkg::lane_state_type state_ff, state_in;
   m4i_pkg::op_type         op_ff;
   logic [1:0]              r_ff, k_ff, j_ff;
   logic [CNT_W-1:0]        mcnt_ff;
   logic                    last_step;

   logic [W-1:0]            mem [16];
   logic [W-1:0]            rd_ff;
   logic [3:0]              rd_addr, addr_a, addr_b;
   logic [1:0]              r0, r1, r2, ck, c1, c2;

   logic [W-1:0]             a_ff;
   logic signed [PROD_W-1:0] b_ff, p_ff, prod_ff, addend;
   logic signed [S_W-1:0]    s_ff;
   logic signed [COF_W-1:0]  acc_ff;
   logic signed [COF_W-1:0]  cof_ff [4];

   logic [DET_W-1:0]        absdet_ff;
   logic                    det_neg_ff;
   logic [NUM_W-1:0]        rem_ff;
   logic [DIV_W-1:0]        d_ff;
   logic [W-1:0]            q_ff;
   logic                    ovf_ff, neg_ff, sat_ff;
   logic [W-1:0]            res_ff [4];
   logic [COF_W-1:0]        mag;
   logic                    ge;
   logic [W-1:0]            q_next, half, pos_max, neg_min;
   logic                    sat_pos, sat_neg;

   assign last_step = (mcnt_ff == CNT_W'(W - 1));

   // operand addresses, {column, row}
   always_comb begin
      r0 = m4i_pkg::skip_idx(ROW_ID, 2'd0);
      r1 = m4i_pkg::skip_idx(ROW_ID, 2'd1);
      r2 = m4i_pkg::skip_idx(ROW_ID, 2'd2);
      ck = m4i_pkg::skip_idx(r_ff, k_ff);
      c1 = m4i_pkg::skip_idx(r_ff, m4i_pkg::next3(k_ff));
      c2 = m4i_pkg::skip_idx(r_ff, m4i_pkg::next3(m4i_pkg::next3(k_ff)));
      case (op_ff)
         m4i_pkg::OP_SA:  addr_a = {c1, r1};
         m4i_pkg::OP_SB:  addr_a = {c2, r1};
         m4i_pkg::OP_ACC: addr_a = {ck, r0};
         default:         addr_a = {2'd0, ROW_ID};
      endcase
      case (op_ff)
         m4i_pkg::OP_SB: addr_b = {c1, r2};
         default:        addr_b = {c2, r2};
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         m4i_pkg::LN_IDLE, m4i_pkg::LN_FIN: begin
            if (ctl.start_cof) state_in = m4i_pkg::LN_ADDR_A;
         end
         m4i_pkg::LN_ADDR_A: state_in = m4i_pkg::LN_ADDR_B;
         m4i_pkg::LN_ADDR_B: state_in = m4i_pkg::LN_LATCH;
         m4i_pkg::LN_LATCH:  state_in = m4i_pkg::LN_MUL;
         m4i_pkg::LN_MUL: begin
            if (last_step) state_in = m4i_pkg::LN_ACCUM;
         end
         m4i_pkg::LN_ACCUM: begin
            if (op_ff == m4i_pkg::OP_DET) state_in = m4i_pkg::LN_HOLD;
            else if (op_ff == m4i_pkg::OP_ACC && k_ff == 2'd2) state_in = m4i_pkg::LN_STORE;
            else state_in = m4i_pkg::LN_ADDR_A;
         end
         m4i_pkg::LN_STORE: state_in = m4i_pkg::LN_ADDR_A;
         m4i_pkg::LN_HOLD: begin
            if (ctl.start_div) state_in = m4i_pkg::LN_DIV_SETUP;
         end
         m4i_pkg::LN_DIV_SETUP: state_in = m4i_pkg::LN_DIV_ADD;
         m4i_pkg::LN_DIV_ADD:   state_in = m4i_pkg::LN_DIV_CHECK;
         m4i_pkg::LN_DIV_CHECK: state_in = m4i_pkg::LN_DIV_ITER;
         m4i_pkg::LN_DIV_ITER: begin
            if (last_step) state_in = m4i_pkg::LN_DIV_END;
         end
         m4i_pkg::LN_DIV_END: begin
            state_in = (j_ff == 2'd3) ? m4i_pkg::LN_FIN : m4i_pkg::LN_DIV_SETUP;
         end
         default: state_in = m4i_pkg::LN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_addr       = (state_ff == m4i_pkg::LN_ADDR_B) ? addr_b : addr_a;
      sts.cof_ready = (state_ff == m4i_pkg::LN_HOLD);
      sts.div_ready = (state_ff == m4i_pkg::LN_FIN);
   end

   // sequencing counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m4i_pkg::LN_IDLE;
         op_ff    <= m4i_pkg::OP_SA;
         r_ff     <= 2'd0;
         k_ff     <= 2'd0;
         j_ff     <= 2'd0;
         mcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            m4i_pkg::LN_IDLE, m4i_pkg::LN_FIN: begin
               if (ctl.start_cof) begin
                  op_ff <= m4i_pkg::OP_SA;
                  r_ff  <= 2'd0;
                  k_ff  <= 2'd0;
               end
            end
            m4i_pkg::LN_LATCH, m4i_pkg::LN_DIV_CHECK: mcnt_ff <= '0;
            m4i_pkg::LN_MUL, m4i_pkg::LN_DIV_ITER:    mcnt_ff <= mcnt_ff + 1'b1;
            m4i_pkg::LN_ACCUM: begin
               case (op_ff)
                  m4i_pkg::OP_SA: op_ff <= m4i_pkg::OP_SB;
                  m4i_pkg::OP_SB: op_ff <= m4i_pkg::OP_ACC;
                  m4i_pkg::OP_ACC: begin
                     if (k_ff != 2'd2) begin
                        k_ff  <= k_ff + 2'd1;
                        op_ff <= m4i_pkg::OP_SA;
                     end
                  end
                  default: op_ff <= op_ff;
               endcase
            end
            m4i_pkg::LN_STORE: begin
               if (r_ff == 2'd3) begin
                  op_ff <= m4i_pkg::OP_DET;
               end else begin
                  r_ff  <= r_ff + 2'd1;
                  k_ff  <= 2'd0;
                  op_ff <= m4i_pkg::OP_SA;
               end
            end
            m4i_pkg::LN_HOLD: begin
               if (ctl.start_div) j_ff <= 2'd0;
            end
            m4i_pkg::LN_DIV_END: j_ff <= j_ff + 2'd1;
            default: j_ff <= j_ff;
         endcase
      end
   end

   assign addend  = a_ff[0] ? b_ff : '0;
   assign mag     = cof_ff[j_ff][COF_W-1] ? -cof_ff[j_ff] : cof_ff[j_ff];
   assign ge      = ({{W{1'b0}}, rem_ff} >= d_ff);
   assign half    = {1'b1, {(W-1){1'b0}}};
   assign pos_max = {1'b0, {(W-1){1'b1}}};
   assign neg_min = half;
   assign sat_pos = ovf_ff || q_ff[W-1];
   assign sat_neg = ovf_ff || (q_ff > half);
   assign q_next  = neg_ff ? (sat_neg ? neg_min : -q_ff) : (sat_pos ? pos_max : q_ff);

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         m4i_pkg::LN_ADDR_B: a_ff <= rd_ff;
         m4i_pkg::LN_LATCH: begin
            p_ff <= '0;
            case (op_ff)
               m4i_pkg::OP_ACC: b_ff <= {{(PROD_W-S_W){s_ff[S_W-1]}}, s_ff};
               m4i_pkg::OP_DET: b_ff <= {{(PROD_W-COF_W){cof_ff[0][COF_W-1]}}, cof_ff[0]};
               default:         b_ff <= {{(PROD_W-W){rd_ff[W-1]}}, rd_ff};
            endcase
         end
         m4i_pkg::LN_MUL: begin
            // top multiplier bit carries negative weight
            p_ff <= last_step ? p_ff - addend : p_ff + addend;
            a_ff <= a_ff >> 1;
            b_ff <= b_ff <<< 1;
         end
         m4i_pkg::LN_ACCUM: begin
            case (op_ff)
               m4i_pkg::OP_SA:  s_ff <= p_ff[S_W-1:0];
               m4i_pkg::OP_SB:  s_ff <= s_ff - p_ff[S_W-1:0];
               m4i_pkg::OP_ACC: acc_ff <= ((k_ff == 2'd0) ? '0 : acc_ff) + p_ff[COF_W-1:0];
               default:         prod_ff <= p_ff;
            endcase
         end
         m4i_pkg::LN_STORE: begin
            cof_ff[r_ff] <= (ROW_ID[0] ^ r_ff[0]) ? -acc_ff : acc_ff;
         end
         m4i_pkg::LN_HOLD: begin
            if (ctl.start_div) begin
               absdet_ff  <= det[DET_W-1] ? -det : det;
               det_neg_ff <= det[DET_W-1];
               sat_ff     <= 1'b0;
            end
         end
         m4i_pkg::LN_DIV_SETUP: begin
            rem_ff <= {{(NUM_W-COF_W){1'b0}}, mag} << SH;
            neg_ff <= cof_ff[j_ff][COF_W-1] ^ det_neg_ff;
         end
         m4i_pkg::LN_DIV_ADD: begin
            // +|det| over 2|det| rounds half away from zero
            rem_ff <= rem_ff + {{(NUM_W-DET_W){1'b0}}, absdet_ff};
            d_ff   <= {{(DIV_W-DET_W){1'b0}}, absdet_ff} << (W + 1);
         end
         m4i_pkg::LN_DIV_CHECK: begin
            ovf_ff <= ge;
            d_ff   <= d_ff >> 1;
            q_ff   <= '0;
         end
         m4i_pkg::LN_DIV_ITER: begin
            if (ge) rem_ff <= rem_ff - d_ff[NUM_W-1:0];
            q_ff <= {q_ff[W-2:0], ge};
            d_ff <= d_ff >> 1;
         end
         m4i_pkg::LN_DIV_END: begin
            res_ff[j_ff] <= q_next;
            sat_ff       <= sat_ff | (neg_ff ? sat_neg : sat_pos);
         end
         default: a_ff <= a_ff;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         res[i] = res_ff[i];
      end
   end

   assign prod = prod_ff;
   assign sat  = sat_ff;

endmodule

/* src/m4i_merge.sv */
// m4i_merge: registered adder tree that sums the four lane products into
// the determinant. Uses m4i_pkg for widths.
module m4i_merge #(
   parameter int ELEM_WIDTH = m4i_pkg::DEF_ELEM_WIDTH
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                en,
   input  logic signed [3:0][m4i_pkg::prod_w(ELEM_WIDTH)-1:0]  prod,
   output logic signed [m4i_pkg::det_w(ELEM_WIDTH)-1:0]        det,
   output logic                                                det_valid
);

   localparam int PROD_W = m4i_pkg::prod_w(ELEM_WIDTH);
   localparam int DET_W  = m4i_pkg::det_w(ELEM_WIDTH);

   logic signed [PROD_W:0]  sum01_ff, sum23_ff;
   logic signed [DET_W-1:0] det_ff;
   logic                    v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= en;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum01_ff <= {prod[0][PROD_W-1], prod[0]} + {prod[1][PROD_W-1], prod[1]};
      sum23_ff <= {prod[2][PROD_W-1], prod[2]} + {prod[3][PROD_W-1], prod[3]};
      if (v1_ff) begin
         det_ff <= {{(DET_W-PROD_W-1){sum01_ff[PROD_W]}}, sum01_ff}
                 + {{(DET_W-PROD_W-1){sum23_ff[PROD_W]}}, sum23_ff};
      end
   end

   assign det       = det_ff;
   assign det_valid = v2_ff;

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for matrix4_inverse (4x4 Q16.16 matrix inverse).
// Depends on m4i_pkg and matrix4_inverse; predicts results with wide exact arithmetic.
module tb_top;

   localparam int EW = m4i_pkg::DEF_ELEM_WIDTH;
   localparam int FB = m4i_pkg::DEF_FRAC_BITS;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};
   localparam logic signed [EW-1:0] ONE  = 1 <<< FB;
   localparam logic signed [EW-1:0] LSB  = 1;

   typedef logic signed [255:0] wint_type;
   typedef logic [255:0] wuint_type;

   typedef enum logic [2:0] {
      CHK_MODEL, CHK_IDENT, CHK_SING, CHK_SATPOS, CHK_SATNEG
   } chk_kind_type;

   typedef struct {
      logic [1:0]             col;
      logic signed [EW-1:0]   e[4];
      chk_kind_type           kind;
   } stim_row_type;

   typedef struct {
      logic [1:0]             col;
      logic signed [EW-1:0]   inv[4];
      logic                   singular;
      logic                   saturated;
      logic                   last;
   } inv_col_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_column_index = '0;
   logic signed [EW-1:0] req_elem_0 = '0, req_elem_1 = '0, req_elem_2 = '0, req_elem_3 = '0;
   logic rsp_valid;
   logic [1:0] rsp_out_column;
   logic signed [EW-1:0] rsp_inv_0, rsp_inv_1, rsp_inv_2, rsp_inv_3;
   logic rsp_singular, rsp_saturated, rsp_last;

   logic signed [EW-1:0] mat_store[16];
   inv_col_type expected_cols[$];
   stim_row_type directed_rows[$];
   int err_count = 0;
   int cycle_count = 0;

   matrix4_inverse DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_column_index(req_column_index),
      .req_elem_0(req_elem_0), .req_elem_1(req_elem_1),
      .req_elem_2(req_elem_2), .req_elem_3(req_elem_3),
      .rsp_valid(rsp_valid), .rsp_out_column(rsp_out_column),
      .rsp_inv_0(rsp_inv_0), .rsp_inv_1(rsp_inv_1),
      .rsp_inv_2(rsp_inv_2), .rsp_inv_3(rsp_inv_3),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic wint_type elem_at(input int r, input int c);
      return wint_type'(mat_store[c*4 + r]);
   endfunction

   // signed cofactor of element (sr, sc)
   function automatic wint_type cofactor_of(input int sr, input int sc);
      int rows[3], cols[3];
      int k;
      wint_type m[3][3];
      wint_type d;
      k = 0;
      for (int i = 0; i < 4; i++) if (i != sr) begin rows[k] = i; k++; end
      k = 0;
      for (int i = 0; i < 4; i++) if (i != sc) begin cols[k] = i; k++; end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) m[i][j] = elem_at(rows[i], cols[j]);
      d = m[0][0] * (m[1][1]*m[2][2] - m[1][2]*m[2][1])
        - m[0][1] * (m[1][0]*m[2][2] - m[1][2]*m[2][0])
        + m[0][2] * (m[1][0]*m[2][1] - m[1][1]*m[2][0]);
      return ((sr + sc) % 2) ? -d : d;
   endfunction

   // exact inverse of the stored matrix, rounded half away, saturated
   function automatic void predict_inverse();
      wint_type cof[4][4];
      wint_type det;
      wuint_type adet, num, q;
      logic neg;
      inv_col_type res;
      det = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) cof[r][c] = cofactor_of(r, c);
      for (int r = 0; r < 4; r++) det += elem_at(r, 0) * cof[r][0];
      adet = det[255] ? wuint_type'(-det) : wuint_type'(det);
      for (int c = 0; c < 4; c++) begin
         res.col = c[1:0];
         res.last = (c == 3);
         res.singular = (det == 0);
         res.saturated = 1'b0;
         for (int r = 0; r < 4; r++) begin
            res.inv[r] = '0;
            if (det != 0) begin
               neg = cof[c][r][255] ^ det[255];
               num = cof[c][r][255] ? wuint_type'(-cof[c][r]) : wuint_type'(cof[c][r]);
               q = ((num << (2*FB + 1)) + adet) / (adet << 1);
               if (!neg) begin
                  if (q >= (wuint_type'(1) << (EW-1))) begin
                     res.inv[r] = EMAX;
                     res.saturated = 1'b1;
                  end else res.inv[r] = q[EW-1:0];
               end else begin
                  if (q > (wuint_type'(1) << (EW-1))) begin
                     res.inv[r] = EMIN;
                     res.saturated = 1'b1;
                  end else res.inv[r] = -q[EW-1:0];
               end
            end
         end
         expected_cols.push_back(res);
      end
   endfunction

   // hand-written results for diagonal and singular matrices
   function automatic void push_typed(input chk_kind_type kind);
      inv_col_type res;
      for (int c = 0; c < 4; c++) begin
         res.col = c[1:0];
         res.last = (c == 3);
         res.singular = (kind == CHK_SING);
         res.saturated = (kind == CHK_SATPOS) || (kind == CHK_SATNEG);
         for (int r = 0; r < 4; r++) begin
            res.inv[r] = '0;
            if (r == c) begin
               case (kind)
                  CHK_IDENT:  res.inv[r] = ONE;
                  CHK_SATPOS: res.inv[r] = EMAX;
                  CHK_SATNEG: res.inv[r] = EMIN;
                  default:    res.inv[r] = '0;
               endcase
            end
         end
         expected_cols.push_back(res);
      end
   endfunction

   function automatic stim_row_type mk(input logic [1:0] c, input logic signed [EW-1:0] a,
         input logic signed [EW-1:0] b, input logic signed [EW-1:0] d,
         input logic signed [EW-1:0] f, input chk_kind_type kind);
      stim_row_type row;
      row.col = c;
      row.e[0] = a; row.e[1] = b; row.e[2] = d; row.e[3] = f;
      row.kind = kind;
      return row;
   endfunction

   function automatic logic signed [EW-1:0] rand_elem();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) return $urandom;
      if (mode == 2) begin
         case ($urandom_range(0, 3))
            0: return EMAX;
            1: return EMIN;
            2: return ONE;
            default: return -ONE;
         endcase
      end
      // roughly -4.0 .. +4.0
      return $signed($urandom_range(0, 1 << (FB + 3))) - (1 << (FB + 2));
   endfunction

   task automatic put_req(input stim_row_type row);
      start <= 1'b1;
      req_column_index <= row.col;
      req_elem_0 <= row.e[0];
      req_elem_1 <= row.e[1];
      req_elem_2 <= row.e[2];
      req_elem_3 <= row.e[3];
      do @(posedge clock); while (busy);
      for (int i = 0; i < 4; i++) mat_store[row.col*4 + i] = row.e[i];
      if (row.col == 2'd3) begin
         if (row.kind == CHK_MODEL) predict_inverse();
         else push_typed(row.kind);
      end
   endtask

   task automatic maybe_idle(input bit allow);
      if (allow && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      inv_col_type exp_c;
      if (!reset && rsp_valid) begin
         if (expected_cols.size() == 0) begin
            $error("unexpected result for column %0d", rsp_out_column);
            err_count++;
         end else begin
            exp_c = expected_cols.pop_front();
            if (rsp_out_column !== exp_c.col) begin
               $error("out_column exp %0d got %0d", exp_c.col, rsp_out_column);
               err_count++;
            end
            if (rsp_inv_0 !== exp_c.inv[0]) begin
               $error("inv_0 exp %0d got %0d", exp_c.inv[0], rsp_inv_0);
               err_count++;
            end
            if (rsp_inv_1 !== exp_c.inv[1]) begin
               $error("inv_1 exp %0d got %0d", exp_c.inv[1], rsp_inv_1);
               err_count++;
            end
            if (rsp_inv_2 !== exp_c.inv[2]) begin
               $error("inv_2 exp %0d got %0d", exp_c.inv[2], rsp_inv_2);
               err_count++;
            end
            if (rsp_inv_3 !== exp_c.inv[3]) begin
               $error("inv_3 exp %0d got %0d", exp_c.inv[3], rsp_inv_3);
               err_count++;
            end
            if (rsp_singular !== exp_c.singular) begin
               $error("singular exp %0b got %0b", exp_c.singular, rsp_singular);
               err_count++;
            end
            if (rsp_saturated !== exp_c.saturated) begin
               $error("saturated exp %0b got %0b", exp_c.saturated, rsp_saturated);
               err_count++;
            end
            if (rsp_last !== exp_c.last) begin
               $error("last exp %0b got %0b", exp_c.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int order[3];
      int tmp, j, n_sent;
      logic signed [EW-1:0] z;
      z = '0;
      // identity, tiny diagonals that overflow both ways, all zero, singular extremes
      for (int c = 0; c < 4; c++)
         directed_rows.push_back(mk(2'(c), c == 0 ? ONE : z, c == 1 ? ONE : z,
            c == 2 ? ONE : z, c == 3 ? ONE : z, CHK_IDENT));
      for (int c = 0; c < 4; c++)
         directed_rows.push_back(mk(2'(c), c == 0 ? LSB : z, c == 1 ? LSB : z,
            c == 2 ? LSB : z, c == 3 ? LSB : z, CHK_SATPOS));
      for (int c = 0; c < 4; c++)
         directed_rows.push_back(mk(2'(c), c == 0 ? -LSB : z, c == 1 ? -LSB : z,
            c == 2 ? -LSB : z, c == 3 ? -LSB : z, CHK_SATNEG));
      for (int c = 0; c < 4; c++) directed_rows.push_back(mk(2'(c), z, z, z, z, CHK_SING));
      directed_rows.push_back(mk(2'd0, EMAX, EMAX, EMAX, EMAX, CHK_SING));
      directed_rows.push_back(mk(2'd1, EMAX, EMAX, EMAX, EMAX, CHK_SING));
      directed_rows.push_back(mk(2'd2, EMIN, EMIN, EMIN, EMIN, CHK_SING));
      directed_rows.push_back(mk(2'd3, EMIN, EMIN, EMIN, EMIN, CHK_SING));
      // out of order and rewritten columns: latest values win
      directed_rows.push_back(mk(2'd1, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, z,
         CHK_MODEL));
      directed_rows.push_back(mk(2'd2, z, 32'sh0000_c000, -32'sh0003_0000, ONE, CHK_MODEL));
      directed_rows.push_back(mk(2'd1, ONE, 32'sh0002_0000, z, -ONE, CHK_MODEL));
      directed_rows.push_back(mk(2'd0, 32'sh0003_0000, ONE, -32'sh0000_8000, z, CHK_MODEL));
      directed_rows.push_back(mk(2'd3, -ONE, z, 32'sh0000_2000, 32'sh0004_0000, CHK_MODEL));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         put_req(directed_rows[i]);
         maybe_idle(1'b1);
      end

      n_sent = directed_rows.size();
      while (n_sent < 430) begin
         row.kind = CHK_MODEL;
         if ($urandom_range(0, 6) == 0) begin
            // stray single column
            row.col = 2'($urandom_range(0, 3));
            for (int i = 0; i < 4; i++) row.e[i] = rand_elem();
            put_req(row);
            n_sent++;
            maybe_idle(n_sent < 370);
         end else begin
            order[0] = 0; order[1] = 1; order[2] = 2;
            for (int i = 2; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int k = 0; k < 4; k++) begin
               row.col = (k == 3) ? 2'd3 : 2'(order[k]);
               for (int i = 0; i < 4; i++) row.e[i] = rand_elem();
               put_req(row);
               n_sent++;
               maybe_idle(n_sent < 370);
            end
         end
      end
      start <= 1'b0;

      while (expected_cols.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (err_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
